// ===== rtl/core/frame_pacer_with_skip_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Frame pacer assertion macros
// Concurrent assertion wrappers on the unit clock and reset.
// ---------------------------------------------------------------------------
`ifndef FRAME_PACER_WITH_SKIP_UNIT_MACROS_SVH
`define FRAME_PACER_WITH_SKIP_UNIT_MACROS_SVH

// check while out of reset
`define FPWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define FPWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fpws_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame pacer package
// Shared widths, codes, configuration record and controller handshake types.
// ---------------------------------------------------------------------------
`default_nettype none

package fpws_pkg;

  localparam int FD_W       = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int SPEED_W    = 2;
  localparam int SKIP_W     = 3;
  localparam int PHASE_W    = 2;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_TIME_W = 32;
  localparam int OUT_PAD_W  = 5;
  localparam int OUT_DATA_W = 2 * OUT_TIME_W + SKIP_W + OUT_PAD_W;
  localparam int OUT_USER_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SKIP_MODE = 3'd4;

  localparam logic [FD_W-1:0] FRAME_DURATION_RST = 20'd16;

  localparam logic [SPEED_W-1:0] SPD_NORMAL = 2'd0;
  localparam logic [SPEED_W-1:0] SPD_FAST   = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;
  localparam logic [SKIP_W-1:0]  SKIP_SAT   = 3'd7;
  localparam logic [SKIP_W-1:0]  SKIP_ONE   = 3'd1;
  localparam logic [SKIP_W-1:0]  SKIP_PAIR  = 3'd2;

  typedef struct packed {
    logic [FD_W-1:0] frame_duration;
    logic            interlaced;
    logic            limit_enable;
    logic            skip_enable;
    logic            half_skip_mode;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRONT,
    S_ELAPSED,
    S_TIMING,
    S_SETTLE,
    S_ADVANCE,
    S_SKIP,
    S_DIV,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic front;
    logic elapsed;
    logic timing;
    logic settle;
    logic advance;
    logic skip_step;
    logic div_step;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ref_pending;
    logic fast_hold;
    logic limit_en;
    logic decide_go;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpws_datapath.sv =====
// ---------------------------------------------------------------------------
// Frame pacer datapath
// Pacing state, wait and lateness arithmetic, repeated-subtraction lateness
// ratio, skip decision and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fpws_datapath
  import fpws_pkg::*;
#(
  parameter int MAX_SKIP   = 4,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [IN_DATA_W-1:0]  in_now,
  input  wire logic [SPEED_W-1:0]    in_speed,
  input  wire logic                  in_odd,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  localparam int TW   = TIME_WIDTH;
  localparam int BW   = (TIME_WIDTH > FD_W) ? TIME_WIDTH : FD_W;
  localparam int QW   = $clog2(MAX_SKIP + 2);
  localparam int NW   = QW + 1;
  localparam int PW   = FD_W + 5;
  localparam logic [QW-1:0] QMAX = QW'(MAX_SKIP + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_SKIP);

  logic [TW-1:0]      last_r, last_nxt;
  logic [BW-1:0]      wb_r, wb_nxt;
  logic [TW-1:0]      late_r, late_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic [PHASE_W-1:0] fp_r, fp_nxt;
  logic               refp_r, refp_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic [TW-1:0]         now_r, now_nxt;
  logic [SPEED_W-1:0]    speed_r, speed_nxt;
  logic                  odd_r, odd_nxt;
  logic [TW-1:0]         wait_r, wait_nxt;
  logic [TW-1:0]         lout_r, lout_nxt;
  logic                  first_r, first_nxt;
  logic [TW-1:0]         elapsed_r, elapsed_nxt;
  logic                  fit_r, fit_nxt;
  logic                  wrap_r, wrap_nxt;
  logic [BW-1:0]         diff_r, diff_nxt;
  logic [TW-1:0]         rem_r, rem_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic [FD_W-1:0]       d_r, d_nxt;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic [OUT_USER_W-1:0] ouser_r, ouser_nxt;

  logic [BW-1:0]     fd_b, el_b, rem_b, d_b;
  logic [TW-1:0]     room, min_w, late_raw;
  logic              skip_busy, fast_next, div_done, q_ge1;
  logic [PW-1:0]     r_p, d_p, r20, r10, d17;
  logic [NW-1:0]     n_il, n_pr_raw, n_pr;
  logic [SKIP_W-1:0] n_il_sat, n_pr_sat, dec_skip;

  assign fd_b      = BW'(cfg.frame_duration);
  assign el_b      = BW'(elapsed_r);
  assign rem_b     = BW'(rem_r);
  assign d_b       = BW'(d_r);
  assign room      = ~now_r;
  assign min_w     = (diff_r < BW'(room)) ? TW'(diff_r) : room;
  assign late_raw  = TW'(diff_r);
  assign skip_busy = (skip_r != '0);
  assign fast_next = (fp_r != PHASE_LAST);
  assign div_done  = (rem_b < d_b) || (quo_r == QMAX);
  assign q_ge1     = (quo_r != '0);

  // lateness ratios: 0.85 as 17/20, 0.15 as 3/20, 0.10 as 1/10, 0.05 as 1/20
  assign r_p = PW'(FD_W'(rem_r));
  assign d_p = PW'(d_r);
  assign r20 = (r_p << 4) + (r_p << 2);
  assign r10 = (r_p << 3) + (r_p << 1);
  assign d17 = (d_p << 4) + d_p;

  assign n_il     = (quo_r > QW'(MAX_SKIP)) ? NMAX : NW'(quo_r) + NW'(quo_r[0]);
  assign n_pr_raw = NW'(quo_r) + NW'(r20 >= d17);
  assign n_pr     = (n_pr_raw >= NMAX) ? NW'(MAX_SKIP - 1) : n_pr_raw;
  assign n_il_sat = (n_il > NW'(SKIP_SAT)) ? SKIP_SAT : SKIP_W'(n_il);
  assign n_pr_sat = (n_pr > NW'(SKIP_SAT)) ? SKIP_SAT : SKIP_W'(n_pr);

  always_comb begin
    dec_skip = skip_r;
    if (!cfg.half_skip_mode) begin
      if (q_ge1 || (r20 > d17)) begin
        if (cfg.interlaced) begin
          if (!odd_r) begin
            dec_skip = n_il_sat;
          end
        end else begin
          dec_skip = n_pr_sat;
        end
      end
    end else if (cfg.interlaced) begin
      if ((q_ge1 || (r10 > d_p)) && !odd_r) begin
        dec_skip = SKIP_PAIR;
      end
    end else if (q_ge1 || (r20 > d_p)) begin
      dec_skip = SKIP_ONE;
    end
  end

  always_comb begin
    last_nxt    = last_r;
    wb_nxt      = wb_r;
    late_nxt    = late_r;
    skip_nxt    = skip_r;
    fp_nxt      = fp_r;
    refp_nxt    = refp_r;
    ovalid_nxt  = ovalid_r;
    now_nxt     = now_r;
    speed_nxt   = speed_r;
    odd_nxt     = odd_r;
    wait_nxt    = wait_r;
    lout_nxt    = lout_r;
    first_nxt   = first_r;
    elapsed_nxt = elapsed_r;
    fit_nxt     = fit_r;
    wrap_nxt    = wrap_r;
    diff_nxt    = diff_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    d_nxt       = d_r;
    odata_nxt   = odata_r;
    ouser_nxt   = ouser_r;

    if (cmd.capture) begin
      now_nxt   = TW'(in_now);
      speed_nxt = in_speed;
      odd_nxt   = in_odd;
    end

    if (cmd.front) begin
      first_nxt = refp_r;
      wait_nxt  = '0;
      lout_nxt  = '0;
      if (refp_r) begin
        refp_nxt = 1'b0;
        last_nxt = now_r;
        wb_nxt   = '0;
        late_nxt = '0;
      end else if (speed_r == SPD_FAST) begin
        fp_nxt   = fast_next ? PHASE_W'(fp_r + PHASE_W'(1)) : '0;
        skip_nxt = skip_busy ? SKIP_W'(fast_next) : SKIP_W'(fast_next) + SKIP_ONE;
      end else if (speed_r != SPD_NORMAL) begin
        wb_nxt   = BW'(TW'(wb_r + fd_b));
        skip_nxt = SKIP_ONE;
      end
    end

    if (cmd.elapsed) begin
      elapsed_nxt = now_r - last_r;
    end

    if (cmd.timing) begin
      fit_nxt  = (el_b <= wb_r) && (now_r >= last_r);
      wrap_nxt = (now_r < last_r);
      diff_nxt = ((el_b <= wb_r) && (now_r >= last_r)) ? wb_r - el_b : el_b - wb_r;
    end

    if (cmd.settle) begin
      if (fit_r) begin
        wait_nxt = min_w + TW'(1);
        wb_nxt   = fd_b;
        late_nxt = '0;
        lout_nxt = '0;
      end else begin
        last_nxt = now_r;
        if (BW'(late_raw) > fd_b) begin
          wb_nxt   = '0;
          late_nxt = wrap_r ? '0 : late_raw;
          lout_nxt = wrap_r ? '0 : late_raw;
        end else begin
          wb_nxt   = fd_b - BW'(late_raw);
          late_nxt = late_raw;
          lout_nxt = late_raw;
        end
      end
    end

    if (cmd.advance && fit_r) begin
      last_nxt = now_r + wait_r;
    end

    if (cmd.skip_step) begin
      if (skip_busy) begin
        skip_nxt = skip_r - SKIP_ONE;
      end else if (cfg.skip_enable) begin
        rem_nxt  = late_r;
        quo_nxt  = '0;
        d_nxt    = (cfg.frame_duration == '0) ? FD_W'(1) : cfg.frame_duration;
        late_nxt = '0;
      end
    end

    if (cmd.div_step && !div_done) begin
      rem_nxt = TW'(rem_b - d_b);
      quo_nxt = quo_r + QW'(1);
    end

    if (cmd.decide) begin
      skip_nxt = dec_skip;
    end

    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {{OUT_PAD_W{1'b0}}, OUT_TIME_W'(lout_r), skip_r, OUT_TIME_W'(wait_r)};
      ouser_nxt  = OUT_USER_W'(first_r);
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      wb_r     <= '0;
      late_r   <= '0;
      skip_r   <= '0;
      fp_r     <= '0;
      refp_r   <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      wb_r     <= wb_nxt;
      late_r   <= late_nxt;
      skip_r   <= skip_nxt;
      fp_r     <= fp_nxt;
      refp_r   <= refp_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    speed_r   <= speed_nxt;
    odd_r     <= odd_nxt;
    wait_r    <= wait_nxt;
    lout_r    <= lout_nxt;
    first_r   <= first_nxt;
    elapsed_r <= elapsed_nxt;
    fit_r     <= fit_nxt;
    wrap_r    <= wrap_nxt;
    diff_r    <= diff_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    d_r       <= d_nxt;
    odata_r   <= odata_nxt;
    ouser_r   <= ouser_nxt;
  end

  assign sts.ref_pending = refp_r;
  assign sts.fast_hold   = (speed_r == SPD_FAST) && skip_busy;
  assign sts.limit_en    = cfg.limit_enable;
  assign sts.decide_go   = !skip_busy && cfg.skip_enable;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire

// ===== rtl/core/fpws_ctrl.sv =====
// ---------------------------------------------------------------------------
// Frame pacer controller
// Sequences one frame event through the datapath and hands off the result.
// ---------------------------------------------------------------------------
`default_nettype none

module fpws_ctrl
  import fpws_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_FRONT;
        end
      end
      S_FRONT: begin
        cmd.front = 1'b1;
        if (sts.ref_pending || sts.fast_hold) begin
          state_nxt = S_OUT;
        end else if (sts.limit_en) begin
          state_nxt = S_ELAPSED;
        end else begin
          state_nxt = S_SKIP;
        end
      end
      S_ELAPSED: begin
        cmd.elapsed = 1'b1;
        state_nxt   = S_TIMING;
      end
      S_TIMING: begin
        cmd.timing = 1'b1;
        state_nxt  = S_SETTLE;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        state_nxt  = S_ADVANCE;
      end
      S_ADVANCE: begin
        cmd.advance = 1'b1;
        state_nxt   = S_SKIP;
      end
      S_SKIP: begin
        cmd.skip_step = 1'b1;
        state_nxt     = sts.decide_go ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_pacer_with_skip_unit.sv =====
// ---------------------------------------------------------------------------
// Frame pacer with frame skipping
// Paces one frame event per frame and decides how many frames to skip.
//
//   Channel  Dir  Handshake               Payload
//   in_      in   in_tvalid/in_tready     tdata now_time; tuser speed, odd_field
//   out_     out  out_tvalid/out_tready   tdata wait, skip, late; tuser first
//   cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A request is captured and runs the front step; a reference or held fast-forward
// frame then goes to output. Otherwise elapsed, timing, settle and advance run with
// the limit on, then skip, subtract loop and decide for a skip decision, and output.
// Synchronous active-low reset clears pacing state; the next request only
// sets the time reference. A waiting result is held in the output register
// while the next request is taken; it stalls only at hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "frame_pacer_with_skip_unit_macros.svh"

module frame_pacer_with_skip_unit
  import fpws_pkg::*;
#(
  parameter int MAX_SKIP   = 4,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] now_time
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [1:0] speed, [2] odd_field
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [31:0] wait_ticks, [34:32] skip_count,
                                                 // [66:35] late_amount, [71:67] zero
  output logic [OUT_USER_W-1:0]      out_tuser,  // [0] first_frame
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [FD_W-1:0]       cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_DURATION: cfg_nxt.frame_duration = cfg_data;
        CFG_INTERLACED:     cfg_nxt.interlaced     = cfg_data[0];
        CFG_LIMIT_ENABLE:   cfg_nxt.limit_enable   = cfg_data[0];
        CFG_SKIP_ENABLE:    cfg_nxt.skip_enable    = cfg_data[0];
        CFG_HALF_SKIP_MODE: cfg_nxt.half_skip_mode = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_duration <= FRAME_DURATION_RST;
      cfg_r.interlaced     <= 1'b0;
      cfg_r.limit_enable   <= 1'b1;
      cfg_r.skip_enable    <= 1'b0;
      cfg_r.half_skip_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpws_datapath #(
    .MAX_SKIP   (MAX_SKIP),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_now     (in_tdata),
    .in_speed   (in_tuser[SPEED_W-1:0]),
    .in_odd     (in_tuser[SPEED_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `FPWS_ASSERT(a_one_request, (in_tvalid && in_tready) |=> !in_tready, "request taken while busy")
  `FPWS_ASSERT(a_first_clean, (out_tvalid && out_tuser[0]) |-> (out_tdata[31:0] == '0 && out_tdata[66:35] == '0), "reference result carries timing")
  `FPWS_ASSERT(a_out_source, $rose(out_tvalid) |-> $past(cmd.load_out), "result raised without load")
  `FPWS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// ===== test/tb_frame_pacer_with_skip_unit.sv =====
// ---------------------------------------------------------------------------
// Frame pacer with frame skipping: self-checking testbench
// Sends frame events, predicts each wait, lateness and skip count in step,
// and checks every result against the oldest prediction. A short directed
// part covers reference, wrap, speed and skip-mode cases; random phases then
// run many settings under several idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_pacer_with_skip_unit;
  import fpws_pkg::*;

  localparam int MAX_SKIP        = 4;
  localparam logic [63:0] TMASK  = 64'hFFFF_FFFF;
  localparam logic [SPEED_W-1:0] SPD_SLOW     = 2'd2;
  localparam logic [SPEED_W-1:0] SPD_SLOW_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam int FD_TOP          = 1000000;
  localparam int N_PHASES        = 17;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES    = MAX_SKIP + 16;
  localparam int QUIET_LIMIT     = 2000;
  localparam logic [63:0] BUDGET_CAP = 64'h00FF_FFFF;

  typedef struct packed {
    logic [OUT_TIME_W-1:0] wait_ticks;
    logic [SKIP_W-1:0]     skip_count;
    logic [OUT_TIME_W-1:0] late_amount;
    logic                  first_frame;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // [31:0] now_time
  logic [IN_USER_W-1:0] in_tuser = '0;   // [1:0] speed, [2] odd_field
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // [31:0] wait_ticks, [34:32] skip_count,
                                         // [66:35] late_amount, [71:67] zero
  logic [OUT_USER_W-1:0] out_tuser;      // [0] first_frame
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FD_W-1:0] cfg_data = '0;

  // predictor settings and state
  logic [63:0] set_fd = 64'd16;
  logic set_interlaced = 1'b0;
  logic set_limit = 1'b1;
  logic set_skip = 1'b0;
  logic set_half = 1'b0;
  logic [63:0] ref_time = '0;
  logic [63:0] budget = '0;
  logic [63:0] lateness = '0;
  int unsigned skips_left = 0;
  int unsigned ff_phase = 0;
  bit awaiting_ref = 1'b1;

  frame_result_t pending_frames[$];
  int n_errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  frame_pacer_with_skip_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned clamp_skip(logic [63:0] n);
    return (n > 64'd7) ? 7 : int'(n);
  endfunction

  // lateness ratios as exact integers: 17/20 = 0.85, 3/20 = 0.15,
  // 1/10 = 0.10, 1/20 = 0.05
  function automatic void plan_skips(bit odd);
    logic [63:0] d, q, r, n;
    d = (set_fd != 0) ? set_fd : 64'd1;
    q = lateness / d;
    r = lateness % d;
    lateness = '0;
    if (!set_half) begin
      if (!(q >= 1 || 20 * r > 17 * d)) return;
      if (set_interlaced) begin
        if (!odd) begin
          n = q;
          if (n > MAX_SKIP) n = 64'(MAX_SKIP);
          else if (n[0]) n = n + 1;
          skips_left = clamp_skip(n);
        end
      end else begin
        n = q + ((20 * r + 3 * d >= 20 * d) ? 64'd1 : 64'd0);
        if (n >= MAX_SKIP) n = 64'(MAX_SKIP - 1);
        skips_left = clamp_skip(n);
      end
    end else if (set_interlaced) begin
      if ((q >= 1 || 10 * r > d) && !odd) skips_left = 2;
    end else if (q >= 1 || 20 * r > d) begin
      skips_left = 1;
    end
  endfunction

  function automatic frame_result_t pace_frame(logic [31:0] stamp, logic [SPEED_W-1:0] speed,
                                               bit odd);
    frame_result_t res;
    logic [63:0] now, elapsed, need, room, hold;
    bit next;
    res = '0;
    now = {32'd0, stamp};
    hold = '0;
    res.skip_count = skips_left[SKIP_W-1:0];
    if (awaiting_ref) begin
      awaiting_ref = 1'b0;
      ref_time = now;
      budget = '0;
      lateness = '0;
      res.first_frame = 1'b1;
      return res;
    end
    if (speed == SPD_FAST) begin
      ff_phase = (ff_phase + 1) & 7;
      next = (ff_phase < 4);
      if (!next) ff_phase = 0;
      if (skips_left > 0) begin
        skips_left = 32'(next);
        res.skip_count = skips_left[SKIP_W-1:0];
        return res;
      end
      skips_left = 1 + next;
    end else if (speed != SPD_NORMAL) begin
      budget = (budget + set_fd) & TMASK;
      skips_left = 1;
    end
    if (set_limit) begin
      elapsed = (now - ref_time) & TMASK;
      if (elapsed <= budget && now >= ref_time) begin
        need = budget - elapsed;
        room = TMASK - now;
        hold = (((need < room) ? need : room) + 1) & TMASK;
        budget = set_fd;
        lateness = '0;
        ref_time = (now + hold) & TMASK;
      end else begin
        lateness = (elapsed - budget) & TMASK;
        if (lateness > set_fd) begin
          budget = '0;
          if (now < ref_time) lateness = '0;
        end else begin
          budget = set_fd - lateness;
        end
        ref_time = now;
      end
      res.wait_ticks = hold[31:0];
      res.late_amount = lateness[31:0];
    end
    if (skips_left > 0) skips_left--;
    else if (set_skip) plan_skips(odd);
    res.skip_count = skips_left[SKIP_W-1:0];
    return res;
  endfunction

  task automatic send_frame(input logic [31:0] stamp, input logic [SPEED_W-1:0] speed,
                            input bit odd);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= stamp;
    in_tuser <= {odd, speed};
    do @(posedge clk); while (!in_tready);
    pending_frames.push_back(pace_frame(stamp, speed, odd));
  endtask

  task automatic send_offset(input logic [63:0] delta, input logic [SPEED_W-1:0] speed,
                             input bit odd);
    logic [63:0] stamp;
    stamp = ref_time + delta;
    send_frame(stamp[31:0], speed, odd);
  endtask

  // hold the input low until every result has been taken
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_DURATION: set_fd = {44'd0, val};
      CFG_INTERLACED:     set_interlaced = val[0];
      CFG_LIMIT_ENABLE:   set_limit = val[0];
      CFG_SKIP_ENABLE:    set_skip = val[0];
      CFG_HALF_SKIP_MODE: set_half = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [FD_W-1:0] fd, input bit il, input bit le,
                               input bit se, input bit hs);
    settle();
    write_reg(CFG_FRAME_DURATION, fd);
    write_reg(CFG_INTERLACED, {19'd0, il});
    write_reg(CFG_LIMIT_ENABLE, {19'd0, le});
    write_reg(CFG_SKIP_ENABLE, {19'd0, se});
    write_reg(CFG_HALF_SKIP_MODE, {19'd0, hs});
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), FD_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_pacing_directed();
    load_settings(FRAME_DURATION_RST, 1'b0, 1'b1, 1'b0, 1'b0);
    send_frame(32'd100, SPD_NORMAL, 1'b0);
    send_frame(32'd100, SPD_NORMAL, 1'b0);
    send_frame(32'd110, SPD_NORMAL, 1'b1);
    send_frame(32'd150, SPD_NORMAL, 1'b0);
    send_frame(32'd400, SPD_NORMAL, 1'b0);
    send_frame(32'hFFFF_FFF0, SPD_NORMAL, 1'b1);
    send_frame(32'hFFFF_FFF8, SPD_SLOW, 1'b0);
    send_frame(32'd3, SPD_NORMAL, 1'b0);
    send_frame(32'hFFFF_FF00, SPD_NORMAL, 1'b1);
    send_frame(32'h0000_0100, SPD_NORMAL, 1'b0);
    repeat (4) send_offset(64'd16, SPD_FAST, 1'b0);
    send_offset(64'd20, SPD_SLOW_ALT, 1'b1);
  endtask

  task automatic test_limit_off();
    load_settings(FRAME_DURATION_RST, 1'b0, 1'b0, 1'b1, 1'b0);
    send_offset(64'd5, SPD_SLOW, 1'b0);
    send_offset(64'd100, SPD_NORMAL, 1'b1);
  endtask

  task automatic test_skip_modes();
    for (int hs = 0; hs < 2; hs++) begin
      for (int il = 0; il < 2; il++) begin
        load_settings(FRAME_DURATION_RST, il[0], 1'b1, 1'b1, hs[0]);
        send_offset(budget + 40, SPD_NORMAL, 1'b0);
        send_offset(64'd13 + 7 * hs, SPD_NORMAL, 1'b1);
      end
    end
  endtask

  task automatic random_frame();
    logic [63:0] b, f, delta;
    logic [31:0] stamp;
    int unsigned bu, fu;
    int pick;
    logic [SPEED_W-1:0] speed;
    pick = $urandom_range(0, 99);
    speed = (pick < 70) ? SPD_NORMAL : (pick < 82) ? SPD_FAST :
            (pick < 94) ? SPD_SLOW : SPD_SLOW_ALT;
    b = (budget > BUDGET_CAP) ? BUDGET_CAP : budget;
    f = set_fd;
    bu = 32'(b);
    fu = 32'(f);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      stamp = $urandom;
    end else if (pick < 12) begin
      stamp = 32'hFFFF_FFFF - $urandom_range(0, 4 * fu + 4);
    end else begin
      case ($urandom_range(0, 3))
        0: delta = 64'($urandom_range(0, bu));
        1: delta = b + 64'($urandom_range(0, fu));
        2: delta = b + 64'($urandom_range(fu, 5 * fu + 1));
        default: delta = b + f * 64'($urandom_range(1, 6)) + 64'($urandom_range(0, fu));
      endcase
      delta = ref_time + delta;
      stamp = delta[31:0];
    end
    send_frame(stamp, speed, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_traffic();
    logic [FD_W-1:0] fd;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: fd = FD_W'(1);
        1: fd = FD_W'(FD_TOP);
        2: fd = '0;
        default: fd = ($urandom_range(0, 3) == 0) ? FD_W'($urandom_range(1, FD_TOP))
                                                  : FD_W'($urandom_range(2, 40));
      endcase
      load_settings(fd, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                    $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (ITEMS_PER_PHASE) random_frame();
    end
  endtask

  task automatic finish_run();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_pacing_directed();
    test_limit_off();
    test_skip_modes();
    test_random_traffic();
    finish_run();
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: result with none expected, tdata %0h tuser %0h",
                 $time, out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("wait_ticks", want.wait_ticks, out_tdata[0 +: OUT_TIME_W]);
        check_field("skip_count", 32'(want.skip_count), 32'(out_tdata[OUT_TIME_W +: SKIP_W]));
        check_field("late_amount", want.late_amount,
                    out_tdata[OUT_TIME_W + SKIP_W +: OUT_TIME_W]);
        check_field("first_frame", 32'(want.first_frame), 32'(out_tuser[0]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
